// ===== rtl/core/voxel_visible_face_extractor_core_macros.svh =====
// Assertion macros shared by the checker files of the voxel face extractor.
`ifndef VOXEL_VISIBLE_FACE_EXTRACTOR_CORE_MACROS_SVH
`define VOXEL_VISIBLE_FACE_EXTRACTOR_CORE_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define VVFE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define VVFE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VVFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/vvfe_pkg.sv =====
// Shared types, constants and lookup functions of the voxel face extractor.
package vvfe_pkg;

    localparam int MAX_SIZE    = 32;
    localparam int POS_W       = 5;
    localparam int KIND_W      = 8;
    localparam int MASK_W      = 6;
    localparam int SIZE_W      = 6;
    localparam int CMD_W       = 2;
    localparam int FACE_W      = 3;
    localparam int COLOR_W     = 8;
    localparam int QCOUNT_W    = 18;
    localparam int BASE_W      = QCOUNT_W + 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int NCOORD_W    = POS_W + 1;
    localparam int EFF_W       = $clog2(MAX_SIZE + 1);
    localparam int CMP_W       = 8;
    localparam int STORE_DEPTH = MAX_SIZE * MAX_SIZE * MAX_SIZE;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam logic [KIND_W-1:0] AIR_RESET   = 8'd0;
    localparam logic [KIND_W-1:0] STONE_RESET = 8'd1;
    localparam logic [KIND_W-1:0] DIRT_RESET  = 8'd2;
    localparam logic [KIND_W-1:0] GRASS_RESET = 8'd3;
    localparam logic [SIZE_W-1:0] SIZE_RESET  = 6'd32;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_MESH  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AIR    = 3'd0,
        CFG_STONE  = 3'd1,
        CFG_DIRT   = 3'd2,
        CFG_GRASS  = 3'd3,
        CFG_SIZE_X = 3'd4,
        CFG_SIZE_Y = 3'd5,
        CFG_SIZE_Z = 3'd6
    } cfg_idx_t;

    typedef enum logic [FACE_W-1:0] {
        FACE_PX = 3'd0,
        FACE_NX = 3'd1,
        FACE_PY = 3'd2,
        FACE_NY = 3'd3,
        FACE_PZ = 3'd4,
        FACE_NZ = 3'd5
    } face_t;

    typedef enum logic [1:0] {
        COL_STONE = 2'd0,
        COL_DIRT  = 2'd1,
        COL_GRASS = 2'd2,
        COL_OTHER = 2'd3
    } color_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [POS_W-1:0]  pos_z;
        logic [KIND_W-1:0] voxel_kind;
        logic [MASK_W-1:0] outside_solid;
    } in_item_t;

    typedef struct packed {
        logic [FACE_W-1:0]  face;
        logic [POS_W-1:0]   out_x;
        logic [POS_W-1:0]   out_y;
        logic [POS_W-1:0]   out_z;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [BASE_W-1:0]  base_vertex;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [EFF_W-1:0] sx;
        logic [EFF_W-1:0] sy;
        logic [EFF_W-1:0] sz;
    } ext_t;

    typedef struct packed {
        logic              inb;
        logic [ADDR_W-1:0] addr;
    } nbr_t;

    function automatic logic [EFF_W-1:0] eff_size(input logic [SIZE_W-1:0] r);
        if (CMP_W'(r) > CMP_W'(MAX_SIZE)) begin
            return EFF_W'(MAX_SIZE);
        end
        return EFF_W'(r);
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(input logic [NCOORD_W-1:0] x,
                                                     input logic [NCOORD_W-1:0] y,
                                                     input logic [NCOORD_W-1:0] z);
        return ADDR_W'(32'(x) + 32'(MAX_SIZE) * 32'(y) + 32'(MAX_SIZE * MAX_SIZE) * 32'(z));
    endfunction

    // Base colors scaled by the face shade and rounded to the nearest 1/256.
    function automatic rgb_t shade_rgb(input color_t color, input face_t face);
        rgb_t  c;
        logic  top;
        logic  bottom;
        top    = (face == FACE_PY);
        bottom = (face == FACE_NY);
        case (color)
            COL_STONE: c = top ? rgb_t'{8'd128, 8'd128, 8'd141} :
                           bottom ? rgb_t'{8'd58, 8'd58, 8'd63} :
                           rgb_t'{8'd96, 8'd96, 8'd106};
            COL_DIRT:  c = top ? rgb_t'{8'd115, 8'd90, 8'd64} :
                           bottom ? rgb_t'{8'd52, 8'd40, 8'd29} :
                           rgb_t'{8'd86, 8'd67, 8'd48};
            COL_GRASS: c = top ? rgb_t'{8'd51, 8'd154, 8'd51} :
                           bottom ? rgb_t'{8'd23, 8'd69, 8'd23} :
                           rgb_t'{8'd38, 8'd115, 8'd38};
            default:   c = top ? rgb_t'{8'd128, 8'd128, 8'd128} :
                           bottom ? rgb_t'{8'd58, 8'd58, 8'd58} :
                           rgb_t'{8'd96, 8'd96, 8'd96};
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/voxel_visible_face_extractor_core.sv =====
// Top level of the voxel face extractor: voxel store, sequencer and quad output.
//
//  Channel  Ports                       Direction  Moves
//  s_       s_valid s_ready s_data      in         one command transaction
//  m_       m_valid m_ready m_data      out        one quad transaction
//  cfg_     cfg_valid cfg_ready         in         one register write
//           cfg_index cfg_data
//
// Write, clear and unused commands end in the acceptance cycle. A mesh command has steps:
// the acceptance cycle reads the voxel, the color state checks it for air, one face step per
// face tests a neighbor read from the single-port store, and the flush state sends the final quad.
// A voxel outside the chunk ends in the acceptance cycle; an air voxel ends after the air check.
// Output stalls hold the sequencer only when a quad has to enter a full output register.
// Reset clears state, valid flags and quad counter, loads config defaults, not the store.
module voxel_visible_face_extractor_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  vvfe_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output vvfe_pkg::out_item_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vvfe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vvfe_pkg::CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_COLOR = 4'b0010,
        S_FACE  = 4'b0100,
        S_FLUSH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [vvfe_pkg::KIND_W-1:0] air_reg, stone_reg, dirt_reg, grass_reg;
    logic [vvfe_pkg::SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;

    logic [vvfe_pkg::KIND_W-1:0] voxel_mem [vvfe_pkg::STORE_DEPTH];
    logic [vvfe_pkg::KIND_W-1:0] rd_reg;
    logic [vvfe_pkg::ADDR_W-1:0] mem_addr;
    logic                        mem_we;

    vvfe_pkg::in_item_t  item_reg, item_next;
    vvfe_pkg::face_t     face_reg, face_next, face_inc, face_sel;
    vvfe_pkg::color_t    color_reg, color_next;
    logic                inb_reg, inb_next;
    logic                pend_valid_reg, pend_valid_next;
    vvfe_pkg::out_item_t pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    vvfe_pkg::out_item_t out_reg, out_next;
    logic [vvfe_pkg::QCOUNT_W-1:0] qcount_reg, qcount_next;

    vvfe_pkg::ext_t      ext;
    vvfe_pkg::nbr_t      nbr;
    vvfe_pkg::out_item_t new_quad;
    vvfe_pkg::rgb_t      quad_rgb;
    logic                in_store;
    logic                mesh_in_range;
    logic                face_open;
    logic                out_free;
    logic                advance;

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    assign ext.sx = vvfe_pkg::eff_size(size_x_reg);
    assign ext.sy = vvfe_pkg::eff_size(size_y_reg);
    assign ext.sz = vvfe_pkg::eff_size(size_z_reg);

    assign in_store = (vvfe_pkg::CMP_W'(s_data.pos_x) < vvfe_pkg::CMP_W'(vvfe_pkg::MAX_SIZE))
                   && (vvfe_pkg::CMP_W'(s_data.pos_y) < vvfe_pkg::CMP_W'(vvfe_pkg::MAX_SIZE))
                   && (vvfe_pkg::CMP_W'(s_data.pos_z) < vvfe_pkg::CMP_W'(vvfe_pkg::MAX_SIZE));

    assign mesh_in_range = (vvfe_pkg::CMP_W'(s_data.pos_x) < vvfe_pkg::CMP_W'(ext.sx))
                        && (vvfe_pkg::CMP_W'(s_data.pos_y) < vvfe_pkg::CMP_W'(ext.sy))
                        && (vvfe_pkg::CMP_W'(s_data.pos_z) < vvfe_pkg::CMP_W'(ext.sz));

    assign face_open = inb_reg ? (rd_reg == air_reg) : !item_reg.outside_solid[face_reg];
    assign out_free  = !out_valid_reg || m_ready;
    assign advance   = !(face_open && pend_valid_reg) || out_free;
    assign face_inc  = (face_reg == vvfe_pkg::FACE_NZ) ? vvfe_pkg::FACE_PX :
                       vvfe_pkg::face_t'(face_reg + vvfe_pkg::FACE_W'(1));

    always_comb begin
        face_sel = vvfe_pkg::FACE_PX;
        if (state_reg == S_FACE) begin
            face_sel = advance ? face_inc : face_reg;
        end
    end

    vvfe_nbr_unit u_nbr (
        .pos_x (item_reg.pos_x),
        .pos_y (item_reg.pos_y),
        .pos_z (item_reg.pos_z),
        .face  (face_sel),
        .ext   (ext),
        .nbr   (nbr)
    );

    assign mem_we   = s_valid && s_ready && (s_data.command == vvfe_pkg::CMD_WRITE) && in_store;
    assign mem_addr = (state_reg == S_IDLE) ?
                      vvfe_pkg::store_addr(vvfe_pkg::NCOORD_W'(s_data.pos_x),
                                           vvfe_pkg::NCOORD_W'(s_data.pos_y),
                                           vvfe_pkg::NCOORD_W'(s_data.pos_z)) :
                      nbr.addr;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            voxel_mem[mem_addr] <= s_data.voxel_kind;
        end
        rd_reg <= voxel_mem[mem_addr];
    end

    assign quad_rgb = vvfe_pkg::shade_rgb(color_reg, face_reg);

    always_comb begin
        new_quad             = '0;
        new_quad.face        = face_reg;
        new_quad.out_x       = item_reg.pos_x;
        new_quad.out_y       = item_reg.pos_y;
        new_quad.out_z       = item_reg.pos_z;
        new_quad.red         = quad_rgb.red;
        new_quad.green       = quad_rgb.green;
        new_quad.blue        = quad_rgb.blue;
        new_quad.base_vertex = {qcount_reg, 2'b00};
        new_quad.last        = 1'b0;
    end

    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        face_next       = face_reg;
        color_next      = color_reg;
        inb_next        = inb_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        qcount_next     = qcount_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    unique case (s_data.command)
                        vvfe_pkg::CMD_MESH: begin
                            if (mesh_in_range) begin
                                item_next  = s_data;
                                state_next = S_COLOR;
                            end
                        end
                        vvfe_pkg::CMD_CLEAR: qcount_next = '0;
                        default: ;
                    endcase
                end
            end
            S_COLOR: begin
                if (rd_reg == air_reg) begin
                    state_next = S_IDLE;
                end else begin
                    if (rd_reg == stone_reg) begin
                        color_next = vvfe_pkg::COL_STONE;
                    end else if (rd_reg == dirt_reg) begin
                        color_next = vvfe_pkg::COL_DIRT;
                    end else if (rd_reg == grass_reg) begin
                        color_next = vvfe_pkg::COL_GRASS;
                    end else begin
                        color_next = vvfe_pkg::COL_OTHER;
                    end
                    face_next  = vvfe_pkg::FACE_PX;
                    inb_next   = nbr.inb;
                    state_next = S_FACE;
                end
            end
            S_FACE: begin
                if (advance) begin
                    if (face_open) begin
                        if (pend_valid_reg) begin
                            out_next       = pend_reg;
                            out_valid_next = 1'b1;
                        end
                        pend_next       = new_quad;
                        pend_valid_next = 1'b1;
                        qcount_next     = qcount_reg + vvfe_pkg::QCOUNT_W'(1);
                    end
                    inb_next  = nbr.inb;
                    face_next = face_inc;
                    if (face_reg == vvfe_pkg::FACE_NZ) begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            qcount_reg     <= '0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            qcount_reg     <= qcount_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg  <= item_next;
        face_reg  <= face_next;
        color_reg <= color_next;
        inb_reg   <= inb_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            air_reg    <= vvfe_pkg::AIR_RESET;
            stone_reg  <= vvfe_pkg::STONE_RESET;
            dirt_reg   <= vvfe_pkg::DIRT_RESET;
            grass_reg  <= vvfe_pkg::GRASS_RESET;
            size_x_reg <= vvfe_pkg::SIZE_RESET;
            size_y_reg <= vvfe_pkg::SIZE_RESET;
            size_z_reg <= vvfe_pkg::SIZE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                vvfe_pkg::CFG_AIR:    air_reg    <= cfg_data;
                vvfe_pkg::CFG_STONE:  stone_reg  <= cfg_data;
                vvfe_pkg::CFG_DIRT:   dirt_reg   <= cfg_data;
                vvfe_pkg::CFG_GRASS:  grass_reg  <= cfg_data;
                vvfe_pkg::CFG_SIZE_X: size_x_reg <= cfg_data[vvfe_pkg::SIZE_W-1:0];
                vvfe_pkg::CFG_SIZE_Y: size_y_reg <= cfg_data[vvfe_pkg::SIZE_W-1:0];
                vvfe_pkg::CFG_SIZE_Z: size_z_reg <= cfg_data[vvfe_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/core/vvfe_nbr_unit.sv =====
// Neighbor step unit: neighbor coordinates, chunk bounds test and store address.
module vvfe_nbr_unit (
    input  logic [vvfe_pkg::POS_W-1:0] pos_x,
    input  logic [vvfe_pkg::POS_W-1:0] pos_y,
    input  logic [vvfe_pkg::POS_W-1:0] pos_z,
    input  vvfe_pkg::face_t            face,
    input  vvfe_pkg::ext_t             ext,
    output vvfe_pkg::nbr_t             nbr
);

    logic [vvfe_pkg::NCOORD_W-1:0] nx;
    logic [vvfe_pkg::NCOORD_W-1:0] ny;
    logic [vvfe_pkg::NCOORD_W-1:0] nz;
    logic                          under;

    always_comb begin
        nx    = vvfe_pkg::NCOORD_W'(pos_x);
        ny    = vvfe_pkg::NCOORD_W'(pos_y);
        nz    = vvfe_pkg::NCOORD_W'(pos_z);
        under = 1'b0;
        unique case (face)
            vvfe_pkg::FACE_PX: nx = nx + vvfe_pkg::NCOORD_W'(1);
            vvfe_pkg::FACE_NX: begin
                under = (pos_x == '0);
                nx    = nx - vvfe_pkg::NCOORD_W'(1);
            end
            vvfe_pkg::FACE_PY: ny = ny + vvfe_pkg::NCOORD_W'(1);
            vvfe_pkg::FACE_NY: begin
                under = (pos_y == '0);
                ny    = ny - vvfe_pkg::NCOORD_W'(1);
            end
            vvfe_pkg::FACE_PZ: nz = nz + vvfe_pkg::NCOORD_W'(1);
            vvfe_pkg::FACE_NZ: begin
                under = (pos_z == '0);
                nz    = nz - vvfe_pkg::NCOORD_W'(1);
            end
            default: under = 1'b1;
        endcase
    end

    assign nbr.inb = !under
                  && (vvfe_pkg::CMP_W'(nx) < vvfe_pkg::CMP_W'(ext.sx))
                  && (vvfe_pkg::CMP_W'(ny) < vvfe_pkg::CMP_W'(ext.sy))
                  && (vvfe_pkg::CMP_W'(nz) < vvfe_pkg::CMP_W'(ext.sz));
    assign nbr.addr = vvfe_pkg::store_addr(nx, ny, nz);

endmodule

// ===== rtl/core/vvfe_checker.sv =====
// Port-level checker for the voxel face extractor and its bind to the top level.
`include "voxel_visible_face_extractor_core_macros.svh"

module vvfe_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input vvfe_pkg::in_item_t              s_data,
    input logic                            m_valid,
    input logic                            m_ready,
    input vvfe_pkg::out_item_t             m_data,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [vvfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [vvfe_pkg::CFG_DATA_W-1:0] cfg_data
);

    // A stalled quad transaction keeps its payload.
    `VVFE_ASSERT_NEXT(a_m_hold, m_valid && !m_ready, m_valid && $stable(m_data), "m_data changed while stalled")

    // More quads follow a quad that is not the last one, so the block is still busy.
    `VVFE_ASSERT_SAME(a_busy_mid_voxel, m_valid && m_ready && !m_data.last, !s_ready, "accepting while a voxel is unfinished")

    // Commands other than mesh finish in their acceptance cycle.
    `VVFE_ASSERT_NEXT(a_short_cmd, s_valid && s_ready && (s_data.command != vvfe_pkg::CMD_MESH), s_ready, "short command kept the block busy")

    // Base vertices are multiples of four.
    `VVFE_ASSERT_SAME(a_base_aligned, m_valid, m_data.base_vertex[1:0] == 2'b00, "unaligned base vertex")

endmodule

bind voxel_visible_face_extractor_core vvfe_checker u_vvfe_checker (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for the voxel face extractor core, predicting every quad from a shadow store.
`timescale 1ns / 1ps

module testbench;
    import vvfe_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int IN_W          = $bits(in_item_t);
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_REPORTS   = 10;
    localparam int STREAM_MESHES = 20;
    localparam int PHASE_QUOTA   = 75;

    logic                  aclk    = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [KIND_W-1:0]   shadow_store [STORE_DEPTH];
    bit                  shadow_written [STORE_DEPTH];
    logic [QCOUNT_W-1:0] quad_total;
    logic [KIND_W-1:0]   air_reg, stone_reg, dirt_reg, grass_reg;
    logic [SIZE_W-1:0]   size_x_reg, size_y_reg, size_z_reg;
    out_item_t           pending_quads [$];

    bit idling;
    int stall_left = 0;
    int mismatches = 0;
    int items_sent = 0;
    int quads_seen = 0;
    int reg_writes = 0;

    voxel_visible_face_extractor_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic int extent_of(logic [SIZE_W-1:0] r);
        return (r > MAX_SIZE) ? MAX_SIZE : int'(r);
    endfunction

    function automatic int voxel_addr(int x, int y, int z);
        return x + MAX_SIZE * (y + MAX_SIZE * z);
    endfunction

    function automatic logic [COLOR_W-1:0] shaded(int base, face_t f);
        int pct;
        pct = (f == FACE_PY) ? 100 : (f == FACE_NY) ? 45 : 75;
        return COLOR_W'((base * pct * 256 + 5000) / 10000);
    endfunction

    function automatic string quad_text(out_item_t q);
        return $sformatf("face %0d pos (%0d,%0d,%0d) rgb (%0d,%0d,%0d) base %0d last %0d",
                         q.face, q.out_x, q.out_y, q.out_z, q.red, q.green, q.blue,
                         q.base_vertex, q.last);
    endfunction

    function automatic void apply_command(in_item_t it);
        int sx, sy, sz, x, y, z, cr, cg, cb, n, i, nx, ny, nz;
        logic [KIND_W-1:0] kind;
        bit solid;
        face_t f;
        out_item_t quads [6];
        sx = extent_of(size_x_reg);
        sy = extent_of(size_y_reg);
        sz = extent_of(size_z_reg);
        x = it.pos_x;
        y = it.pos_y;
        z = it.pos_z;
        n = 0;
        case (it.command)
            CMD_WRITE: begin
                shadow_store[voxel_addr(x, y, z)] = it.voxel_kind;
                shadow_written[voxel_addr(x, y, z)] = 1'b1;
            end
            CMD_CLEAR: begin
                quad_total = '0;
            end
            CMD_MESH: begin
                if (x < sx && y < sy && z < sz && shadow_store[voxel_addr(x, y, z)] != air_reg) begin
                    kind = shadow_store[voxel_addr(x, y, z)];
                    if (kind == stone_reg) begin
                        cr = 50; cg = 50; cb = 55;
                    end else if (kind == dirt_reg) begin
                        cr = 45; cg = 35; cb = 25;
                    end else if (kind == grass_reg) begin
                        cr = 20; cg = 60; cb = 20;
                    end else begin
                        cr = 50; cg = 50; cb = 50;
                    end
                    for (i = 0; i < 6; i++) begin
                        f = face_t'(i);
                        nx = x;
                        ny = y;
                        nz = z;
                        case (f)
                            FACE_PX: nx = nx + 1;
                            FACE_NX: nx = nx - 1;
                            FACE_PY: ny = ny + 1;
                            FACE_NY: ny = ny - 1;
                            FACE_PZ: nz = nz + 1;
                            default: nz = nz - 1;
                        endcase
                        if (nx >= 0 && ny >= 0 && nz >= 0 && nx < sx && ny < sy && nz < sz) begin
                            solid = shadow_store[voxel_addr(nx, ny, nz)] != air_reg;
                        end else begin
                            solid = it.outside_solid[i];
                        end
                        if (!solid) begin
                            quads[n].face        = f;
                            quads[n].out_x       = it.pos_x;
                            quads[n].out_y       = it.pos_y;
                            quads[n].out_z       = it.pos_z;
                            quads[n].red         = shaded(cr, f);
                            quads[n].green       = shaded(cg, f);
                            quads[n].blue        = shaded(cb, f);
                            quads[n].base_vertex = {quad_total, 2'b00};
                            quads[n].last        = 1'b0;
                            quad_total = quad_total + 1'b1;
                            n++;
                        end
                    end
                    if (n > 0) begin
                        quads[n-1].last = 1'b1;
                    end
                    for (i = 0; i < n; i++) begin
                        pending_quads = {pending_quads, quads[i]};
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    always @(posedge aclk) begin : quad_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            quads_seen++;
            if (pending_quads.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("Unexpected quad: %s", quad_text(m_data));
                end
            end else begin
                want = pending_quads.pop_front();
                if (want.face !== m_data.face || want.out_x !== m_data.out_x ||
                    want.out_y !== m_data.out_y || want.out_z !== m_data.out_z ||
                    want.red !== m_data.red || want.green !== m_data.green ||
                    want.blue !== m_data.blue || want.base_vertex !== m_data.base_vertex ||
                    want.last !== m_data.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("Quad mismatch: expected %s", quad_text(want));
                        $display("               actual   %s", quad_text(m_data));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= (stall_left == 0);
        end else if (idling && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 9);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_item(input in_item_t it);
        int gap;
        if (idling && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_command(it);
        items_sent++;
    endtask

    task automatic send_plain(input logic [CMD_W-1:0] cmd);
        in_item_t it;
        it = IN_W'($urandom);
        it.command = cmd;
        send_item(it);
    endtask

    task automatic put_voxel(input int x, input int y, input int z, input logic [KIND_W-1:0] kind);
        in_item_t it;
        it = IN_W'($urandom);
        it.command    = CMD_WRITE;
        it.pos_x      = POS_W'(x);
        it.pos_y      = POS_W'(y);
        it.pos_z      = POS_W'(z);
        it.voxel_kind = kind;
        send_item(it);
    endtask

    function automatic logic [KIND_W-1:0] pick_kind();
        case ($urandom_range(0, 7))
            0, 1, 2: return air_reg;
            3:       return stone_reg;
            4:       return dirt_reg;
            5:       return grass_reg;
            default: return KIND_W'($urandom);
        endcase
    endfunction

    function automatic int pick_coord(int ext);
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            return $urandom_range(0, 3);
        end
        if (r < 80 && ext > 0) begin
            return $urandom_range((ext > 3) ? ext - 3 : 0, ext - 1);
        end
        return $urandom_range(0, 31);
    endfunction

    task automatic ensure_written(input int x, input int y, input int z);
        if (x >= 0 && y >= 0 && z >= 0 && x < MAX_SIZE && y < MAX_SIZE && z < MAX_SIZE) begin
            if (!shadow_written[voxel_addr(x, y, z)]) begin
                put_voxel(x, y, z, pick_kind());
            end
        end
    endtask

    task automatic mesh_at(input int x, input int y, input int z, input logic [MASK_W-1:0] mask);
        in_item_t it;
        ensure_written(x, y, z);
        ensure_written(x + 1, y, z);
        ensure_written(x - 1, y, z);
        ensure_written(x, y + 1, z);
        ensure_written(x, y - 1, z);
        ensure_written(x, y, z + 1);
        ensure_written(x, y, z - 1);
        it = IN_W'($urandom);
        it.command       = CMD_MESH;
        it.pos_x         = POS_W'(x);
        it.pos_y         = POS_W'(y);
        it.pos_z         = POS_W'(z);
        it.outside_solid = mask;
        send_item(it);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_quads.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            CFG_AIR:    air_reg    = val;
            CFG_STONE:  stone_reg  = val;
            CFG_DIRT:   dirt_reg   = val;
            CFG_GRASS:  grass_reg  = val;
            CFG_SIZE_X: size_x_reg = val[SIZE_W-1:0];
            CFG_SIZE_Y: size_y_reg = val[SIZE_W-1:0];
            CFG_SIZE_Z: size_z_reg = val[SIZE_W-1:0];
            default:    ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] air, input logic [7:0] stone,
                              input logic [7:0] dirt, input logic [7:0] grass,
                              input logic [7:0] sx, input logic [7:0] sy, input logic [7:0] sz);
        write_reg(CFG_AIR, air);
        write_reg(CFG_STONE, stone);
        write_reg(CFG_DIRT, dirt);
        write_reg(CFG_GRASS, grass);
        write_reg(CFG_SIZE_X, sx);
        write_reg(CFG_SIZE_Y, sy);
        write_reg(CFG_SIZE_Z, sz);
    endtask

    task automatic test_open_faces();
        put_voxel(0, 0, 0, stone_reg);
        put_voxel(1, 0, 0, air_reg);
        put_voxel(0, 1, 0, air_reg);
        put_voxel(0, 0, 1, air_reg);
        mesh_at(0, 0, 0, 6'h00);
        mesh_at(0, 0, 0, 6'h3F);
        mesh_at(1, 0, 0, 6'h00);
        put_voxel(31, 31, 31, grass_reg);
        put_voxel(30, 31, 31, dirt_reg);
        put_voxel(31, 30, 31, air_reg);
        put_voxel(31, 31, 30, 8'hFF);
        mesh_at(31, 31, 31, 6'h2A);
        mesh_at(31, 31, 30, 6'h15);
    endtask

    task automatic test_counter_commands();
        send_plain(CMD_CLEAR);
        mesh_at(0, 0, 0, 6'h00);
        send_plain(CMD_UNUSED);
        mesh_at(0, 0, 0, 6'h3F);
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_SIZE_X, 8'd1);
        write_reg(CFG_SIZE_Y, 8'd63);
        write_reg(CFG_SIZE_Z, 8'd0);
        mesh_at(0, 0, 0, 6'h00);
        write_reg(CFG_SIZE_Z, 8'd1);
        mesh_at(0, 0, 0, 6'h00);
        mesh_at(1, 0, 0, 6'h00);
        write_reg(CFG_AIR, 8'd255);
        write_reg(CFG_STONE, 8'd7);
        write_reg(CFG_DIRT, 8'd7);
        write_reg(CFG_GRASS, 8'd7);
        put_voxel(0, 0, 0, 8'd7);
        mesh_at(0, 0, 0, 6'h2D);
        write_reg(CFG_STONE, 8'd9);
        mesh_at(0, 0, 0, 6'h12);
    endtask

    task automatic random_phase(input int quota);
        int start, r;
        start = items_sent;
        while (items_sent - start < quota) begin
            r = $urandom_range(0, 99);
            if (r < 62) begin
                mesh_at(pick_coord(extent_of(size_x_reg)), pick_coord(extent_of(size_y_reg)),
                        pick_coord(extent_of(size_z_reg)), MASK_W'($urandom));
            end else if (r < 87) begin
                put_voxel(pick_coord(extent_of(size_x_reg)), pick_coord(extent_of(size_y_reg)),
                          pick_coord(extent_of(size_z_reg)), pick_kind());
            end else if (r < 90) begin
                send_plain(CMD_CLEAR);
            end else if (r < 94) begin
                send_plain(CMD_UNUSED);
            end else begin
                mesh_at($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                        MASK_W'($urandom));
            end
        end
    endtask

    task automatic test_random_traffic();
        idling = 1'b1;
        set_config(8'd0, 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                   8'($urandom_range(1, 255)), 8'($urandom_range(1, 32)),
                   8'($urandom_range(1, 32)), 8'($urandom_range(1, 32)));
        random_phase(PHASE_QUOTA);
        set_config(8'd255, 8'd0, 8'd254, 8'd1, 8'd32, 8'd2, 8'd63);
        random_phase(PHASE_QUOTA);
        idling = 1'b0;
        set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)),
                   8'($urandom_range(0, 40)));
        random_phase(PHASE_QUOTA);
        idling = 1'b1;
        set_config(8'd0, 8'd1, 8'd2, 8'd3, 8'($urandom_range(2, 6)),
                   8'($urandom_range(2, 6)), 8'($urandom_range(2, 6)));
        random_phase(PHASE_QUOTA);
    endtask

    task automatic test_quad_stream();
        idling = 1'b0;
        set_config(8'd0, 8'd1, 8'd2, 8'd3, 8'd32, 8'd32, 8'd32);
        put_voxel(0, 0, 0, stone_reg);
        put_voxel(1, 0, 0, air_reg);
        put_voxel(0, 1, 0, air_reg);
        put_voxel(0, 0, 1, air_reg);
        send_plain(CMD_CLEAR);
        repeat (STREAM_MESHES) mesh_at(0, 0, 0, 6'h00);
    endtask

    initial begin
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        quad_total = '0;
        air_reg    = AIR_RESET;
        stone_reg  = STONE_RESET;
        dirt_reg   = DIRT_RESET;
        grass_reg  = GRASS_RESET;
        size_x_reg = SIZE_RESET;
        size_y_reg = SIZE_RESET;
        size_z_reg = SIZE_RESET;
        idling     = 1'b1;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_open_faces();
        test_counter_commands();
        test_register_extremes();
        test_random_traffic();
        test_quad_stream();

        s_valid <= 1'b0;
        while (pending_quads.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        mismatches += pending_quads.size();

        $display("Sent %0d commands and %0d register writes; checked %0d quads.",
                 items_sent, reg_writes, quads_seen);
        $display("Covered open and culled faces, extent limits, code precedence and %s %0d.",
                 "unbroken quad streams; mismatches:", mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/vvfe_pkg.sv
rtl/core/vvfe_nbr_unit.sv
rtl/core/voxel_visible_face_extractor_core.sv
rtl/core/vvfe_checker.sv
dv/testbench.sv
